// ----- design/pftb_pkg.sv -----
// ----------------------------------------------------------------------------
// pftb_pkg
// Types, constants and helpers shared by the printf to brace format
// translator.
// ----------------------------------------------------------------------------
package pftb_pkg;

  localparam int unsigned PFTB_MAX_PARAM_DEF = 30;

  typedef logic [20:0] cp_t;

  typedef enum logic [2:0] {
    P_LIT,
    P_FLAGS,
    P_WIDTH,
    P_PREC,
    P_PREC_VAL,
    P_SPEC
  } parse_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_FLAG,
    ERR_WIDTH,
    ERR_SPEC,
    ERR_UNEXP,
    ERR_INCOMPLETE,
    ERR_TOO_LONG
  } err_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CHAR,
    ACT_BRACE2,
    ACT_FLUSH
  } act_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_DRAIN,
    T_TAIL
  } top_e;

  typedef struct packed {
    act_e       kind;
    cp_t        ch;
    logic [7:0] tail0;
    logic [7:0] tail1;
    logic       tail_two;
    logic       open;
    logic       push;
    logic [7:0] push_char;
    logic       clear;
    parse_e     state;
    err_e       err;
  } act_t;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LT      = 8'h3C;

  function automatic logic cp_is(input cp_t c, input logic [7:0] ch);
    return c == {13'd0, ch};
  endfunction

  function automatic logic cp_digit(input cp_t c);
    return (c >= cp_t'(8'h30)) && (c <= cp_t'(8'h39));
  endfunction

endpackage

// ----- design/pftb_in_if.sv -----
// ----------------------------------------------------------------------------
// pftb_in_if
// Input channel: one format string codepoint per item.
// ----------------------------------------------------------------------------
interface pftb_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic        end_of_string;

  modport source (output valid, output codepoint, output end_of_string, input ready);
  modport sink (input valid, input codepoint, input end_of_string, output ready);
endinterface

// ----- design/pftb_out_if.sv -----
// ----------------------------------------------------------------------------
// pftb_out_if
// Output channel: one translated character or status word per item.
// ----------------------------------------------------------------------------
interface pftb_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] out_char;
  logic        out_valid;
  logic        run_last;
  logic [2:0]  error_code;

  modport source (output valid, output out_char, output out_valid, output run_last,
                  output error_code, input ready);
  modport sink (input valid, input out_char, input out_valid, input run_last,
                input error_code, output ready);
endinterface

// ----- design/pftb_decode.sv -----
// ----------------------------------------------------------------------------
// pftb_decode
// Classifies one codepoint against the parser state and returns the action
// to take: what to emit, what to buffer and the next parser state.
// ----------------------------------------------------------------------------
module pftb_decode
  import pftb_pkg::*;
#(
  parameter int unsigned MAX_PARAM_CHARS = PFTB_MAX_PARAM_DEF,
  localparam int unsigned LW = $clog2(MAX_PARAM_CHARS + 1)
) (
  input  cp_t           cp_i,
  input  logic          eos_i,
  input  parse_e        state_i,
  input  logic [LW-1:0] len_i,
  input  err_e          err_i,
  output act_t          act_o
);

  parse_e     s;
  logic       done;
  logic       want_push;
  logic [7:0] pch;
  act_t       act;

  always_comb begin
    act           = '0;
    act.kind      = ACT_NONE;
    act.state     = state_i;
    act.err       = err_i;
    s             = state_i;
    done          = 1'b0;
    want_push     = 1'b0;
    pch           = cp_i[7:0];

    if (err_i == ERR_NONE) begin
      if (state_i == P_LIT) begin
        if (cp_is(cp_i, CH_PERCENT)) begin
          act.open  = 1'b1;
          act.state = P_FLAGS;
        end else if (cp_is(cp_i, CH_LBRACE)) begin
          act.kind  = ACT_BRACE2;
          act.ch    = cp_t'(CH_LBRACE);
          act.tail0 = CH_LBRACE;
        end else begin
          act.kind = ACT_CHAR;
          act.ch   = cp_i;
        end
      end else begin
        if (s == P_FLAGS) begin
          if (cp_is(cp_i, "-")) begin
            want_push = 1'b1;
            pch       = CH_LT;
            done      = 1'b1;
          end else if (cp_is(cp_i, "+") || cp_is(cp_i, "0") || cp_is(cp_i, "#")) begin
            want_push = 1'b1;
            done      = 1'b1;
          end else if (cp_is(cp_i, " ")) begin
            act.err = ERR_FLAG;
            done    = 1'b1;
          end else begin
            s = P_WIDTH;
          end
        end
        if (!done && s == P_WIDTH) begin
          if (cp_digit(cp_i)) begin
            act.state = P_WIDTH;
            want_push = 1'b1;
            done      = 1'b1;
          end else if (cp_is(cp_i, "*")) begin
            act.err = ERR_WIDTH;
            done    = 1'b1;
          end else begin
            s = P_PREC;
          end
        end
        if (!done && s == P_PREC) begin
          if (cp_is(cp_i, ".")) begin
            act.state = P_PREC_VAL;
            want_push = 1'b1;
            done      = 1'b1;
          end else begin
            s = P_SPEC;
          end
        end
        if (!done && s == P_PREC_VAL) begin
          if (cp_digit(cp_i)) begin
            act.state = P_PREC_VAL;
            want_push = 1'b1;
            done      = 1'b1;
          end else begin
            s = P_SPEC;
          end
        end
        if (!done) begin
          act.state = s;
          if (cp_is(cp_i, "h") || cp_is(cp_i, "l") || cp_is(cp_i, "j") ||
              cp_is(cp_i, "z") || cp_is(cp_i, "t") || cp_is(cp_i, "L")) begin
            act.kind = ACT_NONE;
          end else if (cp_is(cp_i, CH_PERCENT) && len_i == LW'(1)) begin
            act.kind  = ACT_CHAR;
            act.ch    = cp_t'(CH_PERCENT);
            act.clear = 1'b1;
            act.state = P_LIT;
          end else if (cp_is(cp_i, "c") || cp_is(cp_i, "o") || cp_is(cp_i, "x") ||
                       cp_is(cp_i, "X") || cp_is(cp_i, "e") || cp_is(cp_i, "E")) begin
            act.kind     = ACT_FLUSH;
            act.tail0    = cp_i[7:0];
            act.tail1    = CH_RBRACE;
            act.tail_two = 1'b1;
            act.state    = P_LIT;
          end else if (cp_is(cp_i, "f") || cp_is(cp_i, "F")) begin
            act.kind     = ACT_FLUSH;
            act.tail0    = "f";
            act.tail1    = CH_RBRACE;
            act.tail_two = 1'b1;
            act.state    = P_LIT;
          end else if (cp_is(cp_i, "d") || cp_is(cp_i, "i") || cp_is(cp_i, "u")) begin
            act.kind     = ACT_FLUSH;
            act.tail0    = "d";
            act.tail1    = CH_RBRACE;
            act.tail_two = 1'b1;
            act.state    = P_LIT;
          end else if (cp_is(cp_i, "s")) begin
            act.kind  = ACT_FLUSH;
            act.tail0 = CH_RBRACE;
            act.state = P_LIT;
          end else if (cp_is(cp_i, "a") || cp_is(cp_i, "A") || cp_is(cp_i, "g") ||
                       cp_is(cp_i, "G") || cp_is(cp_i, "n") || cp_is(cp_i, "p")) begin
            act.err = ERR_SPEC;
          end else begin
            act.err = ERR_UNEXP;
          end
        end
        if (want_push) begin
          if (len_i >= LW'(MAX_PARAM_CHARS)) begin
            act.err = ERR_TOO_LONG;
          end else begin
            act.push      = 1'b1;
            act.push_char = pch;
          end
        end
      end
    end

    if (eos_i && act.err == ERR_NONE && act.state != P_LIT) begin
      act.err = ERR_INCOMPLETE;
    end
    act_o = act;
  end

endmodule

// ----- design/printf_to_brace_format_translator.sv -----
// ----------------------------------------------------------------------------
// printf_to_brace_format_translator
// Streams a printf-style format string in and brace-style format text out.
// ----------------------------------------------------------------------------
// A plain codepoint gives one result item; a literal '{' gives two result
// items. A conversion specifier gives L + T result items, where L is the
// length of the buffered parameter text (starting with its '{') and T is one
// or two tail characters: the buffer is a memory with one read port, read
// one character per cycle while the sink takes every item, and no new item
// is taken until the tail is out. An item that emits nothing gives one
// status item.
// ----------------------------------------------------------------------------
module printf_to_brace_format_translator
  import pftb_pkg::*;
#(
  parameter int unsigned MAX_PARAM_CHARS = PFTB_MAX_PARAM_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pftb_in_if.sink     in_i,
  pftb_out_if.source  out_o
);

  localparam int unsigned LW = $clog2(MAX_PARAM_CHARS + 1);
  localparam int unsigned AW = $clog2(MAX_PARAM_CHARS);

  top_e          tst_q, tst_d;
  parse_e        pstate_q;
  logic [LW-1:0] len_q;
  err_e          err_q;
  err_e          item_err_q;
  logic [AW-1:0] idx_q;
  logic [AW-1:0] last_q;
  logic [7:0]    tail0_q, tail1_q;
  logic          tail_two_q;
  logic          tidx_q;

  logic [7:0]    mem [MAX_PARAM_CHARS];
  logic [7:0]    rdata_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;

  logic          out_vld_q;
  cp_t           out_char_q;
  logic          out_ov_q;
  logic          out_last_q;
  err_e          out_err_q;

  logic          load_ok;
  logic          accept;
  logic          out_load;
  cp_t           out_char_d;
  logic          out_ov_d;
  logic          out_last_d;
  err_e          out_err_d;
  act_t          act;

  pftb_decode #(
    .MAX_PARAM_CHARS(MAX_PARAM_CHARS)
  ) u_decode (
    .cp_i   (in_i.codepoint),
    .eos_i  (in_i.end_of_string),
    .state_i(pstate_q),
    .len_i  (len_q),
    .err_i  (err_q),
    .act_o  (act)
  );

  assign load_ok    = !out_vld_q || out_o.ready;
  assign in_i.ready = (tst_q == T_IDLE) && load_ok;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    tst_d = tst_q;
    unique case (tst_q)
      T_IDLE: begin
        if (accept && act.kind == ACT_BRACE2) begin
          tst_d = T_TAIL;
        end else if (accept && act.kind == ACT_FLUSH) begin
          tst_d = T_DRAIN;
        end
      end
      T_DRAIN: begin
        if (load_ok && idx_q == last_q) begin
          tst_d = T_TAIL;
        end
      end
      T_TAIL: begin
        if (load_ok && tidx_q == tail_two_q) begin
          tst_d = T_IDLE;
        end
      end
      default: tst_d = T_IDLE;
    endcase
  end

  always_comb begin
    out_load   = 1'b0;
    out_char_d = '0;
    out_ov_d   = 1'b0;
    out_last_d = 1'b0;
    out_err_d  = item_err_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    we         = accept && (act.open || act.push);
    wa         = act.open ? '0 : len_q[AW-1:0];
    wd         = act.open ? CH_LBRACE : act.push_char;
    unique case (tst_q)
      T_IDLE: begin
        out_err_d = act.err;
        if (accept) begin
          unique case (act.kind)
            ACT_NONE: begin
              out_load   = 1'b1;
              out_last_d = 1'b1;
            end
            ACT_CHAR: begin
              out_load   = 1'b1;
              out_char_d = act.ch;
              out_ov_d   = 1'b1;
              out_last_d = 1'b1;
            end
            ACT_BRACE2: begin
              out_load   = 1'b1;
              out_char_d = act.ch;
              out_ov_d   = 1'b1;
            end
            ACT_FLUSH: begin
              rd_en = 1'b1;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      T_DRAIN: begin
        if (load_ok) begin
          out_load   = 1'b1;
          out_char_d = cp_t'(rdata_q);
          out_ov_d   = 1'b1;
          rd_en      = (idx_q != last_q);
          rd_addr    = idx_q + AW'(1);
        end
      end
      T_TAIL: begin
        if (load_ok) begin
          out_load   = 1'b1;
          out_char_d = cp_t'(tidx_q ? tail1_q : tail0_q);
          out_ov_d   = 1'b1;
          out_last_d = (tidx_q == tail_two_q);
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tst_q      <= T_IDLE;
      pstate_q   <= P_LIT;
      len_q      <= '0;
      err_q      <= ERR_NONE;
      item_err_q <= ERR_NONE;
      idx_q      <= '0;
      tidx_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      tst_q <= tst_d;
      if (accept) begin
        item_err_q <= act.err;
        idx_q      <= '0;
        tidx_q     <= 1'b0;
        if (in_i.end_of_string) begin
          pstate_q <= P_LIT;
          len_q    <= '0;
          err_q    <= ERR_NONE;
        end else begin
          pstate_q <= act.state;
          err_q    <= act.err;
          if (act.open) begin
            len_q <= LW'(1);
          end else if (act.push) begin
            len_q <= len_q + LW'(1);
          end else if (act.clear || act.kind == ACT_FLUSH) begin
            len_q <= '0;
          end
        end
      end else if (tst_q == T_DRAIN && load_ok) begin
        idx_q <= idx_q + AW'(1);
      end else if (tst_q == T_TAIL && load_ok && tidx_q != tail_two_q) begin
        tidx_q <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tail0_q    <= act.tail0;
      tail1_q    <= act.tail1;
      tail_two_q <= act.tail_two;
      last_q     <= AW'(len_q - LW'(1));
    end
    if (out_load) begin
      out_char_q <= out_char_d;
      out_ov_q   <= out_ov_d;
      out_last_q <= out_last_d;
      out_err_q  <= out_err_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_char   = out_char_q;
  assign out_o.out_valid  = out_ov_q;
  assign out_o.run_last   = out_last_q;
  assign out_o.error_code = out_err_q;

endmodule

// ----- tb/printf_to_brace_format_translator_tb.sv -----
// ----------------------------------------------------------------------------
// printf_to_brace_format_translator_tb
// Feeds printf-style format strings into the translator one codepoint item at
// a time and checks every translated character and status item against a
// behavioral translator kept in the testbench. Directed strings come first,
// then random strings that mix literal text, well-formed conversions and
// some broken ones. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
module printf_to_brace_format_translator_tb;
  import pftb_pkg::*;

  localparam int unsigned PARAM_CAP = PFTB_MAX_PARAM_DEF;
  localparam int STIM_TARGET = 360;

  typedef struct packed {
    cp_t  cp;
    logic eos;
  } fmt_item_t;

  typedef struct packed {
    cp_t        ch;
    logic       vld;
    logic       last;
    logic [2:0] err;
  } translated_t;

  logic clk_i;
  logic rst_ni;

  pftb_in_if  in_if ();
  pftb_out_if out_if ();

  printf_to_brace_format_translator #(
    .MAX_PARAM_CHARS(PARAM_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  fmt_item_t   pending_fmt[$];
  translated_t expected_text[$];
  int          fail_count = 0;
  bit          calm = 1'b0;

  parse_e     xl_state = P_LIT;
  logic [7:0] xl_text[PARAM_CAP];
  int         xl_len = 0;
  err_e       xl_err = ERR_NONE;
  cp_t        xl_chars[$];

  fmt_item_t   drive_item;
  int          send_wait;
  int          recv_wait;
  int          stall_draw;
  translated_t got_text;
  translated_t want_text;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) begin
      calm <= ~calm;
    end
  end

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic bit one_of(input cp_t c, input string chars);
    for (int i = 0; i < chars.len(); i++) begin
      if (c == cp_t'(chars[i])) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit is_dec(input cp_t c);
    return (c >= cp_t'("0")) && (c <= cp_t'("9"));
  endfunction

  task automatic buffer_param(input cp_t c);
    if (xl_len >= PARAM_CAP) begin
      xl_err = ERR_TOO_LONG;
    end else begin
      xl_text[xl_len] = c[7:0];
      xl_len++;
    end
  endtask

  task automatic flush_param(input string tail);
    for (int i = 0; i < xl_len; i++) begin
      xl_chars.push_back(cp_t'(xl_text[i]));
    end
    for (int i = 0; i < tail.len(); i++) begin
      xl_chars.push_back(cp_t'(tail[i]));
    end
    xl_len = 0;
    xl_state = P_LIT;
  endtask

  task automatic translate_codepoint(input cp_t c, input logic eos);
    parse_e st;
    bit     done;
    string  tail;

    xl_chars.delete();
    done = 1'b0;
    if (xl_err == ERR_NONE) begin
      st = xl_state;
      if (st == P_LIT) begin
        done = 1'b1;
        if (c == cp_t'("%")) begin
          xl_text[0] = "{";
          xl_len = 1;
          xl_state = P_FLAGS;
        end else if (c == cp_t'("{")) begin
          xl_chars.push_back(cp_t'("{"));
          xl_chars.push_back(cp_t'("{"));
        end else begin
          xl_chars.push_back(c);
        end
      end
      if (!done && st == P_FLAGS) begin
        done = 1'b1;
        if (c == cp_t'("-")) begin
          buffer_param(cp_t'("<"));
        end else if (one_of(c, "+0#")) begin
          buffer_param(c);
        end else if (c == cp_t'(" ")) begin
          xl_err = ERR_FLAG;
        end else begin
          done = 1'b0;
          st = P_WIDTH;
        end
      end
      if (!done && st == P_WIDTH) begin
        done = 1'b1;
        if (is_dec(c)) begin
          xl_state = P_WIDTH;
          buffer_param(c);
        end else if (c == cp_t'("*")) begin
          xl_err = ERR_WIDTH;
        end else begin
          done = 1'b0;
          st = P_PREC;
        end
      end
      if (!done && st == P_PREC) begin
        if (c == cp_t'(".")) begin
          done = 1'b1;
          xl_state = P_PREC_VAL;
          buffer_param(c);
        end else begin
          st = P_SPEC;
        end
      end
      if (!done && st == P_PREC_VAL) begin
        if (is_dec(c)) begin
          done = 1'b1;
          xl_state = P_PREC_VAL;
          buffer_param(c);
        end else begin
          st = P_SPEC;
        end
      end
      if (!done) begin
        xl_state = st;
        if (one_of(c, "hljztL")) begin
        end else if (c == cp_t'("%") && xl_len == 1) begin
          xl_chars.push_back(cp_t'("%"));
          xl_len = 0;
          xl_state = P_LIT;
        end else if (one_of(c, "coxXeE")) begin
          tail = "?}";
          tail[0] = byte'(c[7:0]);
          flush_param(tail);
        end else if (one_of(c, "fF")) begin
          flush_param("f}");
        end else if (one_of(c, "diu")) begin
          flush_param("d}");
        end else if (c == cp_t'("s")) begin
          flush_param("}");
        end else if (one_of(c, "aAgGnp")) begin
          xl_err = ERR_SPEC;
        end else begin
          xl_err = ERR_UNEXP;
        end
      end
    end
    if (eos && xl_err == ERR_NONE && xl_state != P_LIT) begin
      xl_err = ERR_INCOMPLETE;
    end

    if (xl_chars.size() == 0) begin
      expected_text.push_back({cp_t'(0), 1'b0, 1'b1, 3'(xl_err)});
    end else begin
      for (int k = 0; k < xl_chars.size(); k++) begin
        expected_text.push_back({xl_chars[k], 1'b1, 1'(k == xl_chars.size() - 1), 3'(xl_err)});
      end
    end

    if (eos) begin
      xl_state = P_LIT;
      xl_len = 0;
      xl_err = ERR_NONE;
      for (int i = 0; i < PARAM_CAP; i++) begin
        xl_text[i] = 8'h00;
      end
    end
  endtask

  task automatic add_cp(input cp_t c);
    pending_fmt.push_back({c, 1'b0});
  endtask

  task automatic end_string();
    if (pending_fmt.size() > 0) begin
      pending_fmt[pending_fmt.size() - 1].eos = 1'b1;
    end
  endtask

  task automatic add_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) begin
      add_cp(cp_t'(s[i]));
    end
    if (last) begin
      end_string();
    end
  endtask

  function automatic cp_t pick(input string chars);
    return cp_t'(chars[$urandom_range(0, chars.len() - 1)]);
  endfunction

  function automatic cp_t any_literal();
    case ($urandom_range(0, 5))
      0, 1, 2: return cp_t'($urandom_range(32, 126));
      3:       return cp_t'("{");
      4:       return cp_t'("}");
      default: return cp_t'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  task automatic add_digits(input int n);
    repeat (n) add_cp(cp_t'($urandom_range(48, 57)));
  endtask

  task automatic add_conversion();
    int  n;
    bit  plain;

    add_cp(cp_t'("%"));
    if ($urandom_range(0, 19) == 0) begin
      add_digits(PARAM_CAP - 1);
      add_cp(pick("coxXeEfFdius"));
      return;
    end
    plain = 1'b1;
    n = $urandom_range(0, 3);
    if (n > 0) plain = 1'b0;
    repeat (n) add_cp(pick("-+0#"));
    n = $urandom_range(0, 3);
    if (n > 0) plain = 1'b0;
    add_digits(n);
    if ($urandom_range(0, 1) == 0) begin
      plain = 1'b0;
      add_cp(cp_t'("."));
      add_digits($urandom_range(0, 3));
    end
    repeat ($urandom_range(0, 2)) add_cp(pick("hljztL"));
    if (plain && $urandom_range(0, 3) == 0) begin
      add_cp(cp_t'("%"));
    end else begin
      add_cp(pick("coxXeEfFdius"));
    end
  endtask

  task automatic add_broken_conversion();
    add_cp(cp_t'("%"));
    repeat ($urandom_range(0, 2)) add_cp(pick("-+0#"));
    case ($urandom_range(0, 6))
      0: add_cp(cp_t'(" "));
      1: add_cp(cp_t'("*"));
      2: begin
        add_digits($urandom_range(0, 2));
        add_cp(pick("aAgGnp"));
      end
      3: begin
        add_digits($urandom_range(0, 2));
        add_cp(cp_t'($urandom_range(0, 21'h1FFFFF)));
      end
      4: begin
        add_digits($urandom_range(1, 2));
        add_cp(cp_t'("%"));
      end
      5: begin
        add_digits($urandom_range(0, 2));
        end_string();
      end
      default: begin
        add_digits($urandom_range(PARAM_CAP, PARAM_CAP + 4));
        add_cp(cp_t'("d"));
      end
    endcase
  endtask

  task automatic add_random_string();
    int kind;

    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        repeat ($urandom_range(1, 4)) add_cp(any_literal());
      end else if (kind < 85) begin
        add_conversion();
      end else begin
        add_broken_conversion();
      end
    end
    end_string();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.codepoint <= '0;
      in_if.end_of_string <= 1'b0;
      send_wait <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
        in_if.valid <= 1'b0;
      end else if (pending_fmt.size() > 0) begin
        drive_item = pending_fmt.pop_front();
        translate_codepoint(drive_item.cp, drive_item.eos);
        in_if.codepoint <= drive_item.cp;
        in_if.end_of_string <= drive_item.eos;
        in_if.valid <= 1'b1;
        send_wait <= draw_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_text = {out_if.out_char, out_if.out_valid, out_if.run_last, out_if.error_code};
        if (expected_text.size() == 0) begin
          fail_count++;
          if (fail_count < 50) begin
            $display("%0t: unexpected item, expected none, actual char %h valid %b last %b err %0d",
                     $time, got_text.ch, got_text.vld, got_text.last, got_text.err);
          end
        end else begin
          want_text = expected_text.pop_front();
          if (got_text !== want_text) begin
            fail_count++;
            if (fail_count < 50) begin
              $display("%0t: mismatch, expected char %h valid %b last %b err %0d",
                       $time, want_text.ch, want_text.vld, want_text.last, want_text.err);
              $display("%0t:           actual   char %h valid %b last %b err %0d",
                       $time, got_text.ch, got_text.vld, got_text.last, got_text.err);
            end
          end
        end
        stall_draw = draw_gap();
        recv_wait <= stall_draw;
        out_if.ready <= (stall_draw == 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_if.ready <= (recv_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.codepoint = '0;
    in_if.end_of_string = 1'b0;
    out_if.ready = 1'b0;
    for (int i = 0; i < PARAM_CAP; i++) begin
      xl_text[i] = 8'h00;
    end

    add_text("A{}", 1'b0);
    add_cp(cp_t'(21'h1FFFFF));
    add_cp(cp_t'(0));
    end_string();
    add_text("%%", 1'b1);
    add_text("%-+#07.2lf", 1'b1);
    add_text("% x", 1'b1);
    add_text("%*", 1'b1);
    add_text("%g", 1'b1);
    add_text("%5%", 1'b1);
    add_text("%3", 1'b1);

    while (pending_fmt.size() < STIM_TARGET) begin
      add_random_string();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_fmt.size() != 0 || in_if.valid || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (64) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
